// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: case codes and default widths.
// Used by quadratic_root_solver.
package qrs_pkg;

  localparam int unsigned CoefWidthDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned RootWidth    = 33;
  localparam int unsigned ImagWidth    = 32;
  localparam int unsigned CodeWidth    = 3;

  typedef enum logic [CodeWidth-1:0] {
    CaseIdentity     = 3'd0,
    CaseInconsistent = 3'd1,
    CaseLinear       = 3'd2,
    CaseDouble       = 3'd3,
    CaseTwoReal      = 3'd4,
    CaseComplex      = 3'd5
  } case_code_e;

endpackage

// ===== rtl/quadratic_root_solver.sv =====
// Quadratic root solver top level: discriminant, pipelined square root and
// pipelined restoring dividers. Depends on qrs_pkg.
//
// The solver takes one request of signed coefficients a, b and c on the input
// channel (valid/ready) and returns one result per request on the output
// channel: a case code (identity, inconsistent, linear, double root, two real
// roots, complex pair) and the roots in signed fixed point with FRAC_BITS
// fraction bits. Roots truncate toward zero and saturate to 33 bits; the
// imaginary magnitude saturates to 32 bits.
//
// Every request flows through one pipeline: a discriminant stage, one stage
// per bit of the square root, a numerator stage, one stage per quotient bit
// of the three dividers and an output stage. An item can enter in every
// cycle unless a stalled receiver holds the pipeline, so the throughput is
// one request per cycle while the output is drained.
//
// The whole pipeline advances only when its last stage is empty or being
// drained, so a stalled receiver holds every stage in place; nothing is lost
// or repeated. Reset clears all valid bits; the data registers are not reset.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::CoefWidthDef,
  parameter int unsigned FRAC_BITS  = qrs_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COEF_WIDTH-1:0]        coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]        coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [qrs_pkg::CodeWidth-1:0]       case_code_o,
  output logic signed [qrs_pkg::RootWidth-1:0] root_first_o,
  output logic signed [qrs_pkg::RootWidth-1:0] root_second_o,
  output logic [qrs_pkg::ImagWidth-1:0]       imag_part_o
);
  import qrs_pkg::*;

  // |D| <= b^2 + 4|a||c| < 2^(2*CW+1); radicand |D| * 4^FB.
  localparam int unsigned CW       = COEF_WIDTH;
  localparam int unsigned FB       = FRAC_BITS;
  localparam int unsigned DW       = 2 * CW + 1;
  localparam int unsigned RadW     = DW + 2 * FB + 1;
  localparam int unsigned SqrtBits = (RadW + 1) / 2;
  // Numerators: |coef * 2^FB| + S, denominators |b| or |2a| (CW+1 bits).
  localparam int unsigned NumW     = ((CW + FB > SqrtBits) ? CW + FB : SqrtBits) + 1;
  localparam int unsigned DenW     = CW + 1;
  localparam int unsigned QuoBits  = NumW;
  localparam int unsigned SqLat    = SqrtBits;
  localparam int unsigned DvLat    = QuoBits;

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic                 neg_first;
    logic                 neg_second;
  } ctl_t;

  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- Stage 0: discriminant and classification ----------------
  logic signed [CW-1:0] a_w, b_w, c_w;
  assign a_w = coef_a_i[CW-1:0];
  assign b_w = coef_b_i[CW-1:0];
  assign c_w = coef_c_i[CW-1:0];

  logic signed [DW+1:0] disc_w;
  assign disc_w = (DW+2)'(b_w * b_w) - ((DW+2)'(a_w * c_w) <<< 2);

  logic                  v0_q;
  logic [CodeWidth-1:0]  code0_q;
  logic [DW-1:0]         dmag0_q;
  logic signed [CW-1:0]  a0_q, b0_q, c0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a0_q <= a_w;
      b0_q <= b_w;
      c0_q <= c_w;
      dmag0_q <= disc_w[DW+1] ? DW'(-disc_w) : DW'(disc_w);
      if (a_w == '0) begin
        if (b_w == '0) code0_q <= (c_w == '0) ? CaseIdentity : CaseInconsistent;
        else           code0_q <= CaseLinear;
      end else if (disc_w == '0) begin
        code0_q <= CaseDouble;
      end else if (disc_w[DW+1]) begin
        code0_q <= CaseComplex;
      end else begin
        code0_q <= CaseTwoReal;
      end
    end
  end

  // ---------------- Square root: one result bit per stage ----------------
  logic [RadW-1:0]     sq_rem_q  [SqLat+1];
  logic [SqrtBits-1:0] sq_root_q [SqLat+1];
  logic [RadW-1:0]     sq_rad_q  [SqLat+1];
  logic                sq_v_q    [SqLat+1];
  logic [CodeWidth-1:0] sq_code_q [SqLat+1];
  logic signed [CW-1:0] sq_a_q [SqLat+1];
  logic signed [CW-1:0] sq_b_q [SqLat+1];
  logic signed [CW-1:0] sq_c_q [SqLat+1];

  always_comb begin
    sq_rem_q[0]  = '0;
    sq_root_q[0] = '0;
    sq_rad_q[0]  = RadW'(dmag0_q) << (2 * FB);
    sq_v_q[0]    = v0_q;
    sq_code_q[0] = code0_q;
    sq_a_q[0]    = a0_q;
    sq_b_q[0]    = b0_q;
    sq_c_q[0]    = c0_q;
  end

  for (genvar gi = 0; gi < SqLat; gi++) begin : g_sqrt
    localparam int unsigned Sh = 2 * (SqrtBits - 1 - gi);
    logic [RadW+1:0] rem_d, trial_d;
    assign rem_d   = {sq_rem_q[gi], 2'b00} | (RadW+2)'((sq_rad_q[gi] >> Sh) & 2'b11);
    assign trial_d = (RadW+2)'({sq_root_q[gi], 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[gi+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[gi+1] <= sq_v_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_d >= trial_d) begin
          sq_rem_q[gi+1]  <= RadW'(rem_d - trial_d);
          sq_root_q[gi+1] <= {sq_root_q[gi][SqrtBits-2:0], 1'b1};
        end else begin
          sq_rem_q[gi+1]  <= RadW'(rem_d);
          sq_root_q[gi+1] <= {sq_root_q[gi][SqrtBits-2:0], 1'b0};
        end
        sq_rad_q[gi+1]  <= sq_rad_q[gi];
        sq_code_q[gi+1] <= sq_code_q[gi];
        sq_a_q[gi+1]    <= sq_a_q[gi];
        sq_b_q[gi+1]    <= sq_b_q[gi];
        sq_c_q[gi+1]    <= sq_c_q[gi];
      end
    end
  end

  // ---------------- Numerator stage: signed numerators and magnitudes ------
  logic signed [NumW:0] nb_w, nc_w, s_w, n1_w, n2_w;
  logic signed [DenW-1:0] den_w;
  assign nb_w  = -((NumW+1)'(sq_b_q[SqLat]) <<< FB);
  assign nc_w  = -((NumW+1)'(sq_c_q[SqLat]) <<< FB);
  assign s_w   = (NumW+1)'(sq_root_q[SqLat]);
  assign den_w = (sq_code_q[SqLat] == CaseLinear) ? DenW'(sq_b_q[SqLat])
                                                  : (DenW'(sq_a_q[SqLat]) <<< 1);
  always_comb begin
    n2_w = '0;
    unique case (sq_code_q[SqLat])
      CaseLinear:  n1_w = nc_w;
      CaseTwoReal: begin
        n1_w = nb_w + s_w;
        n2_w = nb_w - s_w;
      end
      default:     n1_w = nb_w;
    endcase
  end

  logic                 n_v_q;
  ctl_t                 n_ctl_q;
  logic [NumW-1:0]      n_m1_q, n_m2_q, n_m3_q;
  logic [DenW-1:0]      n_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q <= 1'b0;
    end else if (adv) begin
      n_v_q <= sq_v_q[SqLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_ctl_q.code       <= sq_code_q[SqLat];
      n_ctl_q.neg_first  <= n1_w[NumW] ^ den_w[DenW-1];
      n_ctl_q.neg_second <= n2_w[NumW] ^ den_w[DenW-1];
      n_m1_q  <= n1_w[NumW] ? NumW'(-n1_w) : NumW'(n1_w);
      n_m2_q  <= n2_w[NumW] ? NumW'(-n2_w) : NumW'(n2_w);
      n_m3_q  <= NumW'(sq_root_q[SqLat]);
      n_den_q <= den_w[DenW-1] ? DenW'(-den_w) : DenW'(den_w);
    end
  end

  // ---------------- Dividers: three restoring lanes, one bit per stage -----
  logic [DenW:0]   dv_rem_q [3][DvLat+1];
  logic [NumW-1:0] dv_quo_q [3][DvLat+1];
  logic [NumW-1:0] dv_num_q [3][DvLat+1];
  logic [DenW-1:0] dv_den_q [DvLat+1];
  ctl_t            dv_ctl_q [DvLat+1];
  logic            dv_v_q   [DvLat+1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_rem_q[l][0] = '0;
      dv_quo_q[l][0] = '0;
    end
    dv_num_q[0][0] = n_m1_q;
    dv_num_q[1][0] = n_m2_q;
    dv_num_q[2][0] = n_m3_q;
    dv_den_q[0]    = n_den_q;
    dv_ctl_q[0]    = n_ctl_q;
    dv_v_q[0]      = n_v_q;
  end

  for (genvar gs = 0; gs < DvLat; gs++) begin : g_div
    localparam int unsigned Bit = QuoBits - 1 - gs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[gs+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[gs+1] <= dv_v_q[gs];
      end
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic [DenW+1:0] tr_d;
      assign tr_d = {dv_rem_q[gl][gs], dv_num_q[gl][gs][Bit]};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (tr_d >= (DenW+2)'(dv_den_q[gs])) begin
            dv_rem_q[gl][gs+1] <= (DenW+1)'(tr_d - (DenW+2)'(dv_den_q[gs]));
            dv_quo_q[gl][gs+1] <= dv_quo_q[gl][gs] | (NumW'(1) << Bit);
          end else begin
            dv_rem_q[gl][gs+1] <= (DenW+1)'(tr_d);
            dv_quo_q[gl][gs+1] <= dv_quo_q[gl][gs];
          end
          dv_num_q[gl][gs+1] <= dv_num_q[gl][gs];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_den_q[gs+1] <= dv_den_q[gs];
        dv_ctl_q[gs+1] <= dv_ctl_q[gs];
      end
    end
  end

  // ---------------- Output stage: sign, saturation, zeroing ----------------
  localparam logic [NumW+1:0] PosMax = (NumW+2)'(64'hFFFF_FFFF);
  localparam logic [NumW+1:0] NegMax = (NumW+2)'(64'h1_0000_0000);

  function automatic logic [RootWidth-1:0] sat_signed(logic [NumW-1:0] mag, logic neg);
    logic [NumW+1:0] m;
    m = (NumW+2)'(mag);
    if (neg) begin
      if (m > NegMax) return RootWidth'(64'h1_0000_0000);
      return RootWidth'(-m);
    end
    if (m > PosMax) return RootWidth'(64'hFFFF_FFFF);
    return RootWidth'(m);
  endfunction

  ctl_t            fin_ctl;
  logic [NumW+1:0] q3_w;
  assign fin_ctl = dv_ctl_q[DvLat];
  assign q3_w    = (NumW+2)'(dv_quo_q[2][DvLat]);

  logic [CodeWidth-1:0]  code_q;
  logic [RootWidth-1:0]  r1_q, r2_q;
  logic [ImagWidth-1:0]  im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_v_q[DvLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code_q <= fin_ctl.code;
      r1_q   <= sat_signed(dv_quo_q[0][DvLat], fin_ctl.neg_first);
      r2_q   <= '0;
      im_q   <= '0;
      if (fin_ctl.code == CaseIdentity || fin_ctl.code == CaseInconsistent) r1_q <= '0;
      if (fin_ctl.code == CaseTwoReal)
        r2_q <= sat_signed(dv_quo_q[1][DvLat], fin_ctl.neg_second);
      if (fin_ctl.code == CaseComplex)
        im_q <= (q3_w > PosMax) ? ImagWidth'(64'hFFFF_FFFF) : ImagWidth'(q3_w);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign case_code_o   = code_q;
  assign root_first_o  = r1_q;
  assign root_second_o = r2_q;
  assign imag_part_o   = im_q;

  // ---------------- Assertions ----------------
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (code_q <= CaseComplex))
    else $error("case code out of range");
  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && code_q != CaseTwoReal) |-> (r2_q == '0))
    else $error("second root set outside two-real case");
  a_imag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && code_q != CaseComplex) |-> (im_q == '0))
    else $error("imaginary part set outside complex case");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(r1_q) && $stable(code_q)))
    else $error("result changed while stalled");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for quadratic_root_solver: a queue-fed driver, a
// stalling result monitor and an in-bench root predictor. Depends on qrs_pkg.
`timescale 1ns / 100ps

module tb;
  import qrs_pkg::*;

  // One expected result, computed when its request is accepted.
  typedef struct {
    case_code_e           code;
    logic signed [32:0]   first;
    logic signed [32:0]   second;
    logic [31:0]          imag;
  } root_set_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_set_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] coef_a_i = '0;
  logic signed [15:0] coef_b_i = '0;
  logic signed [15:0] coef_c_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         case_code_o;
  logic signed [32:0] root_first_o;
  logic signed [32:0] root_second_o;
  logic [31:0]        imag_part_o;

  coef_set_t pending_coefs[$];
  root_set_t expected_roots[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  localparam int IdleLimit = 5000;

  quadratic_root_solver dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .out_valid_o, .out_ready_i, .case_code_o, .root_first_o, .root_second_o,
    .imag_part_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Roots clamp to the signed 33-bit range.
  function automatic logic signed [32:0] clamp_root(longint q);
    if (q > 64'sd4294967295) q = 64'sd4294967295;
    if (q < -64'sd4294967296) q = -64'sd4294967296;
    return q[32:0];
  endfunction

  // Exact expected result for one coefficient set.
  function automatic root_set_t solve_roots(coef_set_t cs);
    root_set_t   r;
    longint      sa, sb, sc, disc, nb, den, s, mag_den;
    logic [127:0] rad, sq;
    logic [63:0] root, cand, iq;
    sa = longint'(cs.a);
    sb = longint'(cs.b);
    sc = longint'(cs.c);
    r.code = CaseIdentity;
    r.first = '0;
    r.second = '0;
    r.imag = '0;
    if (sa == 0) begin
      if (sb == 0) begin
        r.code = (sc == 0) ? CaseIdentity : CaseInconsistent;
      end else begin
        r.code = CaseLinear;
        r.first = clamp_root((-sc * 65536) / sb);
      end
    end else begin
      // |b^2 - 4ac| stays below 2^33, so 64-bit arithmetic is exact.
      disc = sb * sb - 4 * sa * sc;
      den = 2 * sa;
      nb = -sb * 65536;
      mag_den = (den < 0) ? -den : den;
      if (disc == 0) begin
        r.code = CaseDouble;
        r.first = clamp_root(nb / den);
      end else begin
        // Bitwise integer square root of |D| scaled by 2^32.
        rad = {64'd0, ((disc < 0) ? -disc : disc)} << 32;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
          cand = root | (64'd1 << i);
          sq = {64'd0, cand} * {64'd0, cand};
          if (sq <= rad) root = cand;
        end
        s = root;
        if (disc > 0) begin
          r.code = CaseTwoReal;
          r.first = clamp_root((nb + s) / den);
          r.second = clamp_root((nb - s) / den);
        end else begin
          r.code = CaseComplex;
          r.first = clamp_root(nb / den);
          iq = root / mag_den;
          r.imag = (iq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : iq[31:0];
        end
      end
    end
    return r;
  endfunction

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk_i) begin
    coef_set_t cs;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cs.a = coef_a_i;
        cs.b = coef_b_i;
        cs.c = coef_c_i;
        expected_roots.push_back(solve_roots(cs));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_coefs.size() > 0) begin
          cs = pending_coefs.pop_front();
          coef_a_i <= cs.a;
          coef_b_i <= cs.b;
          coef_c_i <= cs.c;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stall pattern plus result checking and the watchdog.
  int stall_mode = 0;
  int mode_left = 50;
  int phase_cnt = 0;
  always @(posedge clk_i) begin
    root_set_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_roots.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result code %0d", case_code_o);
        end else begin
          exp_r = expected_roots.pop_front();
          if (case_code_o !== exp_r.code || root_first_o !== exp_r.first ||
              root_second_o !== exp_r.second || imag_part_o !== exp_r.imag) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                       exp_r.code, exp_r.first, exp_r.second, exp_r.imag,
                       case_code_o, root_first_o, root_second_o, imag_part_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("quadratic_root_solver: mismatch");
        $finish;
      end
      // Switch between free flow, random stalls and long on/off stretches.
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      phase_cnt <= phase_cnt + 1;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ((phase_cnt % 23) < 13);
      endcase
    end
  end

  task automatic add_set(int a, int b, int c);
    coef_set_t cs;
    cs.a = 16'(a);
    cs.b = 16'(b);
    cs.c = 16'(c);
    pending_coefs.push_back(cs);
  endtask

  initial begin
    int a, m, k;
    // Directed sets: every case and the coefficient extremes.
    add_set(0, 0, 0);
    add_set(0, 0, -32768);
    add_set(0, 0, 32767);
    add_set(0, 1, -32768);
    add_set(0, -1, -32768);
    add_set(0, -32768, 32767);
    add_set(0, 32767, 1);
    add_set(1, 0, 0);
    add_set(-32768, 0, 0);
    add_set(1, 2, 1);
    add_set(-1, 4, -4);
    add_set(1, 0, -1);
    add_set(3, -7, 0);
    add_set(-32768, 32767, 0);
    add_set(1, -32768, -32768);
    add_set(32767, -32768, 32767);
    add_set(1, 0, 1);
    add_set(-32768, -32768, -32768);
    add_set(32767, 32767, 32767);
    add_set(-1, -1, -32768);
    add_set(1, 32767, -32768);
    for (int n = 0; n < 1900; n++) begin
      k = $urandom_range(0, 9);
      case (k)
        0: add_set(0, $urandom, $urandom);
        1: add_set(0, 0, $urandom);
        2: begin
          // Perfect square: a*(x+m)^2 gives a zero discriminant.
          a = $urandom_range(1, 40);
          if ($urandom_range(0, 1)) a = -a;
          m = $urandom_range(0, 25);
          if ($urandom_range(0, 1)) m = -m;
          add_set(a, 2 * a * m, a * m * m);
        end
        3: add_set($urandom, $urandom, 0);
        4: add_set($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                   $urandom_range(0, 15) - 8);
        default: add_set($urandom, $urandom, $urandom);
      endcase
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_coefs.size() == 0 && !in_valid_i);
    wait (expected_roots.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver: match");
    end else begin
      $display("quadratic_root_solver: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qrs_pkg.sv
rtl/quadratic_root_solver.sv
tb/tb.sv
